FILE: rtl/impulse_storm_level_detector_unit_defines.svh
// Assertion macros for the impulse storm level detector.
// Used by the top level; expects clk and arst_n in scope.
`ifndef IMPULSE_STORM_LEVEL_DETECTOR_UNIT_DEFINES_SVH
`define IMPULSE_STORM_LEVEL_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define ISLD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ISLD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/isld_pkg.sv
// Package for the impulse storm level detector: widths, command codes,
// register indexes and reset values. No dependencies.
package isld_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int DIP_W = SAMPLE_BITS + 1;
	localparam int ACC_W = SAMPLE_BITS + 4;
	localparam int CNT_W = 8;
	localparam int LEVEL_W = 16;
	localparam int IDLE_W = 16;
	localparam int DUTY_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_NOISE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT = 3'd4;

	localparam logic [SAMPLE_BITS-1:0] NOISE_THRESHOLD_RST = SAMPLE_BITS'(70);
	localparam logic [SAMPLE_BITS-1:0] CLIP_LEVEL_RST = SAMPLE_BITS'(1802);
	localparam logic [LEVEL_W-1:0] LEVEL_LIMIT_RST = 16'd7000;
	localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 16'd3600;
	localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 8'd100;

	localparam logic [CNT_W-1:0] IMPULSE_STEP = 8'd32;
	localparam logic [CNT_W-1:0] IMPULSE_SAT = 8'd250;
	localparam logic [LEVEL_W-1:0] CAL_DONE_LEVEL = 16'd255;
	localparam logic [DUTY_W-1:0] DUTY_FIRST = 8'd1;

	// (d / 3) * 2 for an 8-bit duty, divide by 3 via multiply by 171 >> 9
	function automatic logic [DUTY_W-1:0] duty_backoff(input logic [DUTY_W-1:0] d);
		logic [15:0] prod;
		logic [DUTY_W-1:0] q;
		prod = 16'(d) * 16'd171;
		q = DUTY_W'(prod >> 9);
		return DUTY_W'({q, 1'b0});
	endfunction

endpackage

FILE: rtl/impulse_storm_level_detector_unit.sv
// Impulse storm level detector, top level.
// Depends on isld_pkg and impulse_storm_level_detector_unit_defines.svh.
//
// Takes one beat per cycle unless stalled: an ADC sample (cmd 0) or a one-second
// tick (cmd 1), and returns exactly one result beat per input beat, in order,
// showing the state after that item. An input beat is registered in the input
// stage, processed by the average / impulse / warning logic and lands in the
// result register; throughput is one beat per cycle while the output is not
// stalled, and the input side only stalls while the result register is full and
// stalled. After reset the block runs a calibration sweep of the supply duty, one
// sample per step. Configuration registers are written by the user through cfg_wr_en /
// cfg_index / cfg_wdata, and only while the block is idle; the block does not enforce this.
`include "impulse_storm_level_detector_unit_defines.svh"

module impulse_storm_level_detector_unit
	import isld_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    cmd,
	input  logic [SAMPLE_BITS-1:0]  sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    impulse,
	output logic [DUTY_W-1:0]       duty,
	output logic                    calibrating,
	output logic                    cal_failed,
	output logic [SAMPLE_BITS-1:0]  sample_average,
	output logic signed [DIP_W-1:0] dip,
	output logic [CNT_W-1:0]        impulses_x32,
	output logic [LEVEL_W-1:0]      warning,
	output logic [IDLE_W-1:0]       idle_seconds
);

	// configuration
	logic [SAMPLE_BITS-1:0] noise_threshold_q;
	logic [SAMPLE_BITS-1:0] clip_level_q;
	logic [LEVEL_W-1:0]     level_limit_q;
	logic [IDLE_W-1:0]      idle_limit_q;
	logic [DUTY_W-1:0]      duty_limit_q;

	// detector state
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [LEVEL_W-1:0]     level_q;
	logic [IDLE_W-1:0]      idle_q;
	logic [DUTY_W-1:0]      duty_q;
	logic                   cal_q;
	logic                   fail_q;
	logic                   first_q;

	// input stage
	logic                   valid_s1;
	logic                   cmd_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	// result register
	logic                   out_valid_q;
	logic                   impulse_q;
	logic signed [DIP_W-1:0] dip_q;

	logic in_accept;
	logic advance;

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// next-state logic
	logic [SAMPLE_BITS-1:0] avg_n;
	logic [CNT_W-1:0]       cnt_n;
	logic [LEVEL_W-1:0]     level_n;
	logic [IDLE_W-1:0]      idle_n;
	logic [DUTY_W-1:0]      duty_n;
	logic                   cal_n;
	logic                   fail_n;
	logic                   first_n;
	logic                   imp_n;
	logic signed [DIP_W-1:0] dip_n;

	logic [ACC_W-1:0]       acc;
	logic [SAMPLE_BITS-1:0] avg_upd;
	logic signed [DIP_W-1:0] dip_upd;
	logic [CNT_W:0]         cnt_sum;
	logic [DUTY_W:0]        duty_inc;
	logic [LEVEL_W:0]       w_sum;
	logic [LEVEL_W-8:0]     decay;
	logic [LEVEL_W:0]       w_dec;
	logic [IDLE_W-1:0]      idle_inc;

	always_comb begin
		acc = {avg_q, 4'b0000} - ACC_W'(avg_q) + ACC_W'(sample_s1);
		avg_upd = acc[ACC_W-1:4];
		dip_upd = $signed({1'b0, avg_upd}) - $signed({1'b0, sample_s1});
		cnt_sum = {1'b0, cnt_q} + {1'b0, IMPULSE_STEP};
		duty_inc = {1'b0, duty_q} + (DUTY_W+1)'(1);
		w_sum = {1'b0, level_q} + ((cnt_q > IMPULSE_STEP) ? (LEVEL_W+1)'(cnt_q) : '0);
		decay = w_sum[LEVEL_W:8];
		w_dec = w_sum - (LEVEL_W+1)'(decay);
		idle_inc = idle_q + IDLE_W'(1);

		avg_n = avg_q;
		cnt_n = cnt_q;
		level_n = level_q;
		idle_n = idle_q;
		duty_n = duty_q;
		cal_n = cal_q;
		fail_n = fail_q;
		first_n = first_q;
		imp_n = 1'b0;
		dip_n = '0;

		if (cal_q) begin
			if (cmd_s1 == CMD_SAMPLE) begin
				if (sample_s1 > clip_level_q) begin
					duty_n = duty_backoff(duty_q);
					cal_n = 1'b0;
					level_n = CAL_DONE_LEVEL;
					if (first_q) begin
						first_n = 1'b0;
						avg_n = sample_s1;
						cnt_n = '0;
						idle_n = '0;
					end
				end else if (duty_inc > {1'b0, duty_limit_q}) begin
					duty_n = DUTY_FIRST;
					fail_n = 1'b1;
				end else begin
					duty_n = duty_inc[DUTY_W-1:0];
				end
			end
		end else if (cmd_s1 == CMD_SAMPLE) begin
			avg_n = avg_upd;
			dip_n = dip_upd;
			if (!dip_upd[DIP_W-1] && (dip_upd[SAMPLE_BITS-1:0] >= noise_threshold_q)) begin
				imp_n = 1'b1;
				cnt_n = (cnt_sum >= {1'b0, IMPULSE_SAT}) ? IMPULSE_SAT : cnt_sum[CNT_W-1:0];
			end
		end else begin
			level_n = (w_dec > {1'b0, level_limit_q}) ? level_limit_q : w_dec[LEVEL_W-1:0];
			cnt_n = '0;
			if (decay == '0) begin
				if (idle_inc >= idle_limit_q) begin
					idle_n = '0;
					cal_n = 1'b1;
					duty_n = DUTY_FIRST;
					level_n = '0;
					fail_n = 1'b0;
				end else begin
					idle_n = idle_inc;
				end
			end else begin
				idle_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_threshold_q <= NOISE_THRESHOLD_RST;
			clip_level_q <= CLIP_LEVEL_RST;
			level_limit_q <= LEVEL_LIMIT_RST;
			idle_limit_q <= IDLE_LIMIT_RST;
			duty_limit_q <= DUTY_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_NOISE_THRESHOLD: noise_threshold_q <= cfg_wdata[SAMPLE_BITS-1:0];
				REG_CLIP_LEVEL: clip_level_q <= cfg_wdata[SAMPLE_BITS-1:0];
				REG_LEVEL_LIMIT: level_limit_q <= cfg_wdata[LEVEL_W-1:0];
				REG_IDLE_LIMIT: idle_limit_q <= cfg_wdata[IDLE_W-1:0];
				REG_DUTY_LIMIT: duty_limit_q <= cfg_wdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1 <= cmd;
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
			cnt_q <= '0;
			level_q <= '0;
			idle_q <= '0;
			duty_q <= DUTY_FIRST;
			cal_q <= 1'b1;
			fail_q <= 1'b0;
			first_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				avg_q <= avg_n;
				cnt_q <= cnt_n;
				level_q <= level_n;
				idle_q <= idle_n;
				duty_q <= duty_n;
				cal_q <= cal_n;
				fail_q <= fail_n;
				first_q <= first_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			impulse_q <= imp_n;
			dip_q <= dip_n;
		end
	end

	assign out_valid = out_valid_q;
	assign impulse = impulse_q;
	assign dip = dip_q;
	assign duty = duty_q;
	assign calibrating = cal_q;
	assign cal_failed = fail_q;
	assign sample_average = avg_q;
	assign impulses_x32 = cnt_q;
	assign warning = cal_q ? '0 : level_q;
	assign idle_seconds = idle_q;

	`ISLD_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q, "result beat lost after advance")
	`ISLD_ASSERT_NOW(a_impulse_not_cal, out_valid_q && impulse_q, !cal_q && !dip_q[DIP_W-1], "impulse during calibration or negative dip")
	`ISLD_ASSERT_NOW(a_count_sat, out_valid_q, cnt_q <= IMPULSE_SAT, "impulse count above saturation")
	`ISLD_ASSERT_NEXT(a_stalled_hold, out_valid_q && out_stall && !advance, out_valid_q && $stable(level_q) && $stable(avg_q), "state moved while result stalled")

endmodule

FILE: verif/impulse_storm_level_detector_unit_checker.sv
// Checker for the impulse storm level detector: watches the config port and both
// beat channels, predicts every result from its own copy of the detector state
// and compares it field by field. Depends on isld_pkg.
module impulse_storm_level_detector_unit_checker
	import isld_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic                    cmd,
	input  logic [SAMPLE_BITS-1:0]  sample,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic                    impulse,
	input  logic [DUTY_W-1:0]       duty,
	input  logic                    calibrating,
	input  logic                    cal_failed,
	input  logic [SAMPLE_BITS-1:0]  sample_average,
	input  logic signed [DIP_W-1:0] dip,
	input  logic [CNT_W-1:0]        impulses_x32,
	input  logic [LEVEL_W-1:0]      warning,
	input  logic [IDLE_W-1:0]       idle_seconds,
	output int                      reports_due,
	output int                      fail_count,
	output int                      results_checked,
	output int                      sweeps_done,
	output int                      sweep_overruns,
	output int                      impulse_hits
);

	typedef struct packed {
		logic                    impulse;
		logic [DUTY_W-1:0]       duty;
		logic                    calibrating;
		logic                    cal_failed;
		logic [SAMPLE_BITS-1:0]  sample_average;
		logic signed [DIP_W-1:0] dip;
		logic [CNT_W-1:0]        impulses_x32;
		logic [LEVEL_W-1:0]      warning;
		logic [IDLE_W-1:0]       idle_seconds;
	} detector_report_t;

	// register copies
	logic [SAMPLE_BITS-1:0] thr_q;
	logic [SAMPLE_BITS-1:0] clip_q;
	logic [LEVEL_W-1:0]     level_max_q;
	logic [IDLE_W-1:0]      idle_max_q;
	logic [DUTY_W-1:0]      duty_max_q;

	// detector state
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [CNT_W-1:0]       hits_x32_q;
	logic [LEVEL_W-1:0]     level_q;
	logic [IDLE_W-1:0]      idle_q;
	logic [DUTY_W-1:0]      duty_q;
	logic                   sweeping;
	logic                   sweep_failed;
	logic                   seed_avg;

	detector_report_t expected_reports[$];
	detector_report_t want, got;
	string diff;

	task automatic begin_sweep();
		sweeping = 1'b1;
		duty_q = DUTY_FIRST;
		level_q = '0;
		sweep_failed = 1'b0;
	endtask

	task automatic advance_detector(input logic c, input logic [SAMPLE_BITS-1:0] s,
		output detector_report_t r);
		int acc;
		int decay;
		int d;
		r = '0;
		if (sweeping) begin
			if (c == CMD_SAMPLE) begin
				if (s > clip_q) begin
					acc = (int'(duty_q) / 3) * 2;
					duty_q = acc[DUTY_W-1:0];
					sweeping = 1'b0;
					level_q = CAL_DONE_LEVEL;
					sweeps_done++;
					if (seed_avg) begin
						seed_avg = 1'b0;
						avg_q = s;
						hits_x32_q = '0;
						idle_q = '0;
					end
				end else begin
					acc = int'(duty_q) + 1;
					if (acc > int'(duty_max_q)) begin
						acc = 1;
						sweep_failed = 1'b1;
						sweep_overruns++;
					end
					duty_q = acc[DUTY_W-1:0];
				end
			end
		end else if (c == CMD_SAMPLE) begin
			acc = (int'(avg_q) * 15 + int'(s)) / 16;
			avg_q = acc[SAMPLE_BITS-1:0];
			d = int'(avg_q) - int'(s);
			r.dip = d[DIP_W-1:0];
			if (d >= int'(thr_q)) begin
				r.impulse = 1'b1;
				impulse_hits++;
				acc = int'(hits_x32_q) + int'(IMPULSE_STEP);
				if (acc >= int'(IMPULSE_SAT))
					acc = int'(IMPULSE_SAT);
				hits_x32_q = acc[CNT_W-1:0];
			end
		end else begin
			acc = int'(level_q);
			if (hits_x32_q > IMPULSE_STEP)
				acc += int'(hits_x32_q);
			decay = acc >> 8;
			acc -= decay;
			if (acc > int'(level_max_q))
				acc = int'(level_max_q);
			level_q = acc[LEVEL_W-1:0];
			hits_x32_q = '0;
			if (decay == 0) begin
				idle_q = idle_q + 1'b1;
				if (idle_q >= idle_max_q) begin
					idle_q = '0;
					begin_sweep();
				end
			end else begin
				idle_q = '0;
			end
		end
		r.duty = duty_q;
		r.calibrating = sweeping;
		r.cal_failed = sweep_failed;
		r.sample_average = avg_q;
		r.impulses_x32 = hits_x32_q;
		r.warning = sweeping ? '0 : level_q;
		r.idle_seconds = idle_q;
	endtask

	task automatic note_failure(input string msg);
		if (fail_count < 10)
			$display("[%0t] result %0d: %s", $realtime, results_checked, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q = NOISE_THRESHOLD_RST;
			clip_q = CLIP_LEVEL_RST;
			level_max_q = LEVEL_LIMIT_RST;
			idle_max_q = IDLE_LIMIT_RST;
			duty_max_q = DUTY_LIMIT_RST;
			avg_q = '0;
			hits_x32_q = '0;
			idle_q = '0;
			seed_avg = 1'b1;
			begin_sweep();
			expected_reports.delete();
			reports_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.impulse = impulse;
				got.duty = duty;
				got.calibrating = calibrating;
				got.cal_failed = cal_failed;
				got.sample_average = sample_average;
				got.dip = dip;
				got.impulses_x32 = impulses_x32;
				got.warning = warning;
				got.idle_seconds = idle_seconds;
				if (expected_reports.size() == 0) begin
					note_failure("result beat with nothing expected");
				end else begin
					want = expected_reports.pop_front();
					diff = "";
					if (got.impulse !== want.impulse)
						diff = {diff, $sformatf(" impulse exp %0d got %0d", want.impulse, got.impulse)};
					if (got.duty !== want.duty)
						diff = {diff, $sformatf(" duty exp %0d got %0d", want.duty, got.duty)};
					if (got.calibrating !== want.calibrating)
						diff = {diff, $sformatf(" calibrating exp %0d got %0d",
							want.calibrating, got.calibrating)};
					if (got.cal_failed !== want.cal_failed)
						diff = {diff, $sformatf(" cal_failed exp %0d got %0d",
							want.cal_failed, got.cal_failed)};
					if (got.sample_average !== want.sample_average)
						diff = {diff, $sformatf(" sample_average exp %0d got %0d",
							want.sample_average, got.sample_average)};
					if (got.dip !== want.dip)
						diff = {diff, $sformatf(" dip exp %0d got %0d", want.dip, got.dip)};
					if (got.impulses_x32 !== want.impulses_x32)
						diff = {diff, $sformatf(" impulses_x32 exp %0d got %0d",
							want.impulses_x32, got.impulses_x32)};
					if (got.warning !== want.warning)
						diff = {diff, $sformatf(" warning exp %0d got %0d", want.warning, got.warning)};
					if (got.idle_seconds !== want.idle_seconds)
						diff = {diff, $sformatf(" idle_seconds exp %0d got %0d",
							want.idle_seconds, got.idle_seconds)};
					if (diff != "")
						note_failure({"mismatch:", diff});
				end
				results_checked++;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_NOISE_THRESHOLD: thr_q = cfg_wdata[SAMPLE_BITS-1:0];
					REG_CLIP_LEVEL:      clip_q = cfg_wdata[SAMPLE_BITS-1:0];
					REG_LEVEL_LIMIT:     level_max_q = cfg_wdata[LEVEL_W-1:0];
					REG_IDLE_LIMIT:      idle_max_q = cfg_wdata[IDLE_W-1:0];
					REG_DUTY_LIMIT:      duty_max_q = cfg_wdata[DUTY_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				advance_detector(cmd, sample, want);
				expected_reports.push_back(want);
			end
			reports_due <= expected_reports.size();
		end
	end

endmodule

FILE: verif/impulse_storm_level_detector_unit_tb.sv
// Testbench top for the impulse storm level detector: clock, reset, register
// settings, sample/tick stimulus with random gaps and receiver stalls, verdict.
// Depends on isld_pkg, the detector RTL and impulse_storm_level_detector_unit_checker.
module impulse_storm_level_detector_unit_tb;
	import isld_pkg::*;

	localparam int N_PH = 6;
	localparam int QUIET_LIMIT = 3000;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    cmd = CMD_SAMPLE;
	logic [SAMPLE_BITS-1:0]  sample = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    impulse;
	logic [DUTY_W-1:0]       duty;
	logic                    calibrating;
	logic                    cal_failed;
	logic [SAMPLE_BITS-1:0]  sample_average;
	logic signed [DIP_W-1:0] dip;
	logic [CNT_W-1:0]        impulses_x32;
	logic [LEVEL_W-1:0]      warning;
	logic [IDLE_W-1:0]       idle_seconds;

	int reports_due;
	int fail_count;
	int results_checked;
	int sweeps_done;
	int sweep_overruns;
	int impulse_hits;

	// per-phase register settings and stream shape
	int ph_thr[N_PH]   = '{70, 0, 4095, 40, 120, 70};
	int ph_clip[N_PH]  = '{1802, 4095, 0, 3000, 2500, 1802};
	int ph_level[N_PH] = '{7000, 0, 65535, 20000, 7000, 7000};
	int ph_idle[N_PH]  = '{8, 1, 0, 20, 65535, 3600};
	int ph_duty[N_PH]  = '{100, 255, 1, 2, 0, 100};
	int ph_base[N_PH]  = '{2000, 1500, 10, 3200, 1000, 2200};
	int ph_tick[N_PH]  = '{2, 1, 5, 2, 2, 2};
	int ph_items[N_PH] = '{210, 340, 150, 300, 200, 150};

	int n_samples = 0;
	int n_ticks = 0;
	bit hold_off = 1'b0;

	impulse_storm_level_detector_unit dut (.*);

	impulse_storm_level_detector_unit_checker report_check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int base, input bit storm);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < (storm ? 50 : 8))
			v = $urandom_range(0, base / 2);
		else if (r < (storm ? 60 : 18))
			v = $urandom_range(0, 4095);
		else if (r < (storm ? 64 : 22))
			v = $urandom_range(0, 1) ? 4095 : 0;
		else
			v = base + $urandom_range(0, 30) - 15;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[SAMPLE_BITS-1:0];
	endfunction

	task automatic send_beat(input logic c, input logic [SAMPLE_BITS-1:0] s, input bit no_gap);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		gap = 0;
		if (!no_gap) begin
			if (r >= 90)
				gap = $urandom_range(8, 40);
			else if (r >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		sample <= s;
		do @(posedge clk); while (in_stall);
		if (c == CMD_TICK)
			n_ticks++;
		else
			n_samples++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v[CFG_DATA_W-1:0];
		@(posedge clk);
	endtask

	// receiver: short stalls, some long ones, free runs, and one long hold-off
	initial begin
		int r;
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				out_stall <= 1'b1;
				n = 80;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					out_stall <= 1'b0;
					n = $urandom_range(1, 6);
				end else if (r < 60) begin
					out_stall <= 1'b0;
					n = $urandom_range(40, 150);
				end else if (r < 94) begin
					out_stall <= 1'b1;
					n = $urandom_range(1, 3);
				end else begin
					out_stall <= 1'b1;
					n = $urandom_range(10, 30);
				end
			end
			repeat (n) @(posedge clk);
		end
	end

	// watchdog: cycles with no beat on either channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic c;
		logic [SAMPLE_BITS-1:0] s;
		bit storm;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: tick while sweeping, sweep steps, clip boundary, first-sweep seed,
		// impulse saturation, warning add with decay, negative dip, calm tick
		send_beat(CMD_TICK, 12'd0, 1'b0);
		send_beat(CMD_SAMPLE, 12'd0, 1'b0);
		send_beat(CMD_SAMPLE, 12'd1802, 1'b0);
		send_beat(CMD_SAMPLE, 12'd1803, 1'b0);
		repeat (8) send_beat(CMD_SAMPLE, 12'd0, 1'b0);
		send_beat(CMD_TICK, 12'd4095, 1'b0);
		send_beat(CMD_SAMPLE, 12'd4095, 1'b0);
		send_beat(CMD_SAMPLE, 12'd4095, 1'b0);
		send_beat(CMD_TICK, 12'd0, 1'b0);
		send_beat(CMD_SAMPLE, 12'd2048, 1'b0);
		send_beat(CMD_SAMPLE, 12'd1, 1'b0);
		send_beat(CMD_TICK, 12'd2730, 1'b0);

		for (int p = 0; p < N_PH; p++) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while (reports_due != 0) @(posedge clk);
			write_reg(REG_NOISE_THRESHOLD, ph_thr[p]);
			write_reg(REG_CLIP_LEVEL, ph_clip[p]);
			write_reg(REG_LEVEL_LIMIT, ph_level[p]);
			write_reg(REG_IDLE_LIMIT, ph_idle[p]);
			write_reg(REG_DUTY_LIMIT, ph_duty[p]);
			cfg_wr_en <= 1'b0;
			if (p == 0)
				hold_off = 1'b1;
			storm = 1'b0;
			for (int i = 0; i < ph_items[p]; i++) begin
				c = ($urandom_range(0, 15) < ph_tick[p]) ? CMD_TICK : CMD_SAMPLE;
				if (c == CMD_TICK) begin
					s = SAMPLE_BITS'($urandom_range(0, 4095));
					storm = ($urandom_range(0, 3) == 0);
				end else begin
					s = pick_sample(ph_base[p], storm);
				end
				send_beat(c, s, ((i / 64) % 3) == 0);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Covered %0d samples and %0d ticks over %0d register settings, %0d results checked.",
			n_samples, n_ticks, N_PH + 1, results_checked);
		$display("Predicted %0d impulses, %0d finished sweeps and %0d sweep overruns.",
			impulse_hits, sweeps_done, sweep_overruns);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
